>>> sv/cbrfc_pkg.sv
`default_nettype none

package cbrfc_pkg;

    // Field widths of one transaction in each direction
    localparam int OP_W    = 3;
    localparam int LINE_W  = 6;
    localparam int SLICE_W = 6;
    localparam int SLOT_W  = 1;
    localparam int COUNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PROBE   = 3'd0,  // count range of spin line, stage inverted range
        OP_COMMIT  = 3'd1,  // write staged word back to its spin line
        OP_KCOUNT  = 3'd2,  // count range of kink line
        OP_KREAD   = 3'd3,  // read one kink bit
        OP_KTOGGLE = 3'd4,  // read and invert one kink bit
        OP_LCOUNT  = 3'd5   // count whole spin line
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [LINE_W-1:0]  line;
        logic [SLICE_W-1:0] first_slice;
        logic [SLICE_W-1:0] last_slice;
        logic [SLICE_W-1:0] bit_slice;
        logic [SLOT_W-1:0]  slot;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] ones_count;
        logic               bit_value;
    } t_out_item;

endpackage

`default_nettype wire

>>> sv/cbrfc_ram.sv
`default_nettype none

module cbrfc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> sv/circular_bit_range_flip_count_core.sv
`default_nettype none
// Pipeline: stage 1 holds the accepted transaction, then the result register.
// Throughput: one transaction per cycle while i_stall does not hold the output;
// set by the single read-modify-write pass over one spin word and one
// kink word, with one popcount per item.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears the
// per-line valid bits, so every line reads as zero until written; no sweep.
module circular_bit_range_flip_count_core #(
    parameter int LINE_COUNT  = 64,
    parameter int SLICE_COUNT = 64,
    parameter int SLOT_COUNT  = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire cbrfc_pkg::t_in_item   i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output cbrfc_pkg::t_out_item       o_data
);

    import cbrfc_pkg::*;

    // Only lines reachable through the 6-bit line field are stored.
    localparam int LINE_SPAN = 1 << LINE_W;
    localparam int DEPTH     = (LINE_COUNT < LINE_SPAN) ? LINE_COUNT : LINE_SPAN;
    localparam int LW        = $clog2(DEPTH);
    localparam int SW        = $clog2(SLICE_COUNT);
    localparam int CW        = $clog2(SLICE_COUNT + 1);
    localparam int SLW       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLICE_SPAN = 1 << SLICE_W;

    // ------------------------------------------------------------------
    // Handshake
    //   stage 1 holds the accepted transaction while the store words are
    //   read; it retires into the output register, which may be stalled.
    // ------------------------------------------------------------------
    logic acc;
    logic s1_go;

    logic                  r_s1_vld;
    logic [OP_W-1:0]       r_s1_op;
    logic [LW-1:0]         r_s1_line;
    logic [SW-1:0]         r_s1_a;
    logic [SW-1:0]         r_s1_b;
    logic [SW-1:0]         r_s1_t;
    logic [SLW-1:0]        r_s1_slot;
    logic                  r_s1_spin_ok;
    logic                  r_s1_kink_ok;

    logic                  r_out_vld;
    t_out_item             r_out;

    assign s1_go   = r_s1_vld & ~(r_out_vld & i_stall);
    assign o_stall = r_s1_vld & r_out_vld & i_stall;
    assign acc     = i_valid & ~o_stall;

    // ------------------------------------------------------------------
    // Index reduction: line, slices and slot wrap at their counts.
    // ------------------------------------------------------------------
    logic [LW-1:0]  n_line;
    logic [SW-1:0]  n_a;
    logic [SW-1:0]  n_b;
    logic [SW-1:0]  n_t;
    logic [SLW-1:0] n_slot;

    always_comb begin
        n_line = '0;
        for (int k = 0; k < LINE_SPAN; k++) begin
            if (i_data.line == LINE_W'(k)) begin
                n_line = LW'(k % DEPTH);
            end
        end
    end

    always_comb begin
        n_a = '0;
        n_b = '0;
        n_t = '0;
        for (int k = 0; k < SLICE_SPAN; k++) begin
            if (i_data.first_slice == SLICE_W'(k)) begin
                n_a = SW'(k % SLICE_COUNT);
            end
            if (i_data.last_slice == SLICE_W'(k)) begin
                n_b = SW'(k % SLICE_COUNT);
            end
            if (i_data.bit_slice == SLICE_W'(k)) begin
                n_t = SW'(k % SLICE_COUNT);
            end
        end
    end

    assign n_slot = (SLOT_COUNT > 1) ? SLW'(i_data.slot) : '0;

    // ------------------------------------------------------------------
    // Stores: one RAM per store, read at acceptance, written at retire.
    // A valid bit per line stands in for the reset clear.
    // ------------------------------------------------------------------
    logic [DEPTH-1:0]       r_spin_ok;
    logic [DEPTH-1:0]       r_kink_ok;

    logic                   spin_we;
    logic [LW-1:0]          spin_wa;
    logic [SLICE_COUNT-1:0] spin_wd;
    logic [SLICE_COUNT-1:0] spin_rd;

    logic                   kink_we;
    logic [SLICE_COUNT-1:0] kink_wd;
    logic [SLICE_COUNT-1:0] kink_rd;

    cbrfc_ram #(
        .WIDTH (SLICE_COUNT),
        .DEPTH (DEPTH)
    ) u_spin_ram (
        .i_clk     (i_clk),
        .i_wr_en   (spin_we),
        .i_wr_addr (spin_wa),
        .i_wr_data (spin_wd),
        .i_rd_en   (acc),
        .i_rd_addr (n_line),
        .o_rd_data (spin_rd)
    );

    cbrfc_ram #(
        .WIDTH (SLICE_COUNT),
        .DEPTH (DEPTH)
    ) u_kink_ram (
        .i_clk     (i_clk),
        .i_wr_en   (kink_we),
        .i_wr_addr (r_s1_line),
        .i_wr_data (kink_wd),
        .i_rd_en   (acc),
        .i_rd_addr (n_line),
        .o_rd_data (kink_rd)
    );

    // Last write of each store. A read issued on the same edge as a write
    // sees stale data; the forward copy always holds the newest contents
    // of its line, so it is safe to prefer it whenever the line matches.
    logic                   r_fwd_spin_vld;
    logic [LW-1:0]          r_fwd_spin_line;
    logic [SLICE_COUNT-1:0] r_fwd_spin_data;
    logic                   r_fwd_kink_vld;
    logic [LW-1:0]          r_fwd_kink_line;
    logic [SLICE_COUNT-1:0] r_fwd_kink_data;

    // Staging slots (probe writes, commit reads)
    logic [SLICE_COUNT-1:0] r_stg_word [SLOT_COUNT];
    logic [LW-1:0]          r_stg_line [SLOT_COUNT];
    logic                   stg_we;
    logic [SLICE_COUNT-1:0] stg_word;

    // ------------------------------------------------------------------
    // Stage 1 datapath
    // ------------------------------------------------------------------
    // Popcount as a balanced adder tree over a zero-padded 64-bit word
    function automatic logic [CW-1:0] f_pop(input logic [SLICE_COUNT-1:0] x);
        logic [63:0] v;
        logic [1:0]  c2  [32];
        logic [2:0]  c4  [16];
        logic [3:0]  c8  [8];
        logic [4:0]  c16 [4];
        logic [5:0]  c32 [2];
        logic [6:0]  c64;
        v = 64'(x);
        for (int k = 0; k < 32; k++) begin
            c2[k] = {1'b0, v[2*k]} + {1'b0, v[2*k+1]};
        end
        for (int k = 0; k < 16; k++) begin
            c4[k] = {1'b0, c2[2*k]} + {1'b0, c2[2*k+1]};
        end
        for (int k = 0; k < 8; k++) begin
            c8[k] = {1'b0, c4[2*k]} + {1'b0, c4[2*k+1]};
        end
        for (int k = 0; k < 4; k++) begin
            c16[k] = {1'b0, c8[2*k]} + {1'b0, c8[2*k+1]};
        end
        for (int k = 0; k < 2; k++) begin
            c32[k] = {1'b0, c16[2*k]} + {1'b0, c16[2*k+1]};
        end
        c64 = {1'b0, c32[0]} + {1'b0, c32[1]};
        return CW'(c64);
    endfunction

    logic [SLICE_COUNT-1:0] spin_w;
    logic [SLICE_COUNT-1:0] kink_w;
    logic [SLICE_COUNT-1:0] ge_a;
    logic [SLICE_COUNT-1:0] le_b;
    logic [SLICE_COUNT-1:0] range_m;
    logic [SLICE_COUNT-1:0] pop_src;
    logic [CW-1:0]          count;
    logic                   bit_v;

    always_comb begin
        if (r_fwd_spin_vld && (r_fwd_spin_line == r_s1_line)) begin
            spin_w = r_fwd_spin_data;
        end else begin
            spin_w = r_s1_spin_ok ? spin_rd : '0;
        end
        if (r_fwd_kink_vld && (r_fwd_kink_line == r_s1_line)) begin
            kink_w = r_fwd_kink_data;
        end else begin
            kink_w = r_s1_kink_ok ? kink_rd : '0;
        end
    end

    // Circular range: plain span when first <= last, else the two ends.
    // One past last equal to first gives the whole line.
    always_comb begin
        ge_a = {SLICE_COUNT{1'b1}} << r_s1_a;
        le_b = {SLICE_COUNT{1'b1}} >> (SW'(SLICE_COUNT - 1) - r_s1_b);
        range_m = (r_s1_a <= r_s1_b) ? (ge_a & le_b) : (ge_a | le_b);
    end

    always_comb begin
        pop_src  = '0;
        bit_v    = 1'b0;
        spin_we  = 1'b0;
        spin_wa  = r_s1_line;
        spin_wd  = r_stg_word[r_s1_slot];
        kink_we  = 1'b0;
        kink_wd  = kink_w ^ (SLICE_COUNT'(1) << r_s1_t);
        stg_we   = 1'b0;
        stg_word = spin_w ^ range_m;
        case (r_s1_op)
            OP_PROBE: begin
                pop_src = spin_w & range_m;
                stg_we  = s1_go;
            end
            OP_COMMIT: begin
                spin_we = s1_go;
                spin_wa = r_stg_line[r_s1_slot];
            end
            OP_KCOUNT: begin
                pop_src = kink_w & range_m;
            end
            OP_KREAD: begin
                bit_v = kink_w[r_s1_t];
            end
            OP_KTOGGLE: begin
                bit_v   = kink_w[r_s1_t];
                kink_we = s1_go;
            end
            OP_LCOUNT: begin
                pop_src = spin_w;
            end
            default: begin
                pop_src = '0;
            end
        endcase
        count = f_pop(pop_src);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic n_s1_vld;
    logic n_out_vld;

    assign n_s1_vld  = acc ? 1'b1 : (s1_go ? 1'b0 : r_s1_vld);
    assign n_out_vld = s1_go ? 1'b1 : (r_out_vld & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_spin_ok      <= '0;
            r_kink_ok      <= '0;
            r_fwd_spin_vld <= 1'b0;
            r_fwd_kink_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (spin_we) begin
                r_spin_ok[spin_wa] <= 1'b1;
                r_fwd_spin_vld     <= 1'b1;
            end
            if (kink_we) begin
                r_kink_ok[r_s1_line] <= 1'b1;
                r_fwd_kink_vld       <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_op      <= i_data.operation;
            r_s1_line    <= n_line;
            r_s1_a       <= n_a;
            r_s1_b       <= n_b;
            r_s1_t       <= n_t;
            r_s1_slot    <= n_slot;
            r_s1_spin_ok <= r_spin_ok[n_line];
            r_s1_kink_ok <= r_kink_ok[n_line];
        end
        if (s1_go) begin
            r_out.ones_count <= COUNT_W'(count);
            r_out.bit_value  <= bit_v;
        end
        if (spin_we) begin
            r_fwd_spin_line <= spin_wa;
            r_fwd_spin_data <= spin_wd;
        end
        if (kink_we) begin
            r_fwd_kink_line <= r_s1_line;
            r_fwd_kink_data <= kink_wd;
        end
        if (stg_we) begin
            r_stg_word[r_s1_slot] <= stg_word;
            r_stg_line[r_s1_slot] <= r_s1_line;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

`ifndef SYNTH
    // a retiring transaction writes at most one store
    a_one_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(spin_we && kink_we))
        else $error("spin and kink stores written in the same cycle");

    // a new result appears only in the cycle after a stage 1 retire
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(s1_go))
        else $error("result valid without a retiring transaction");

    // forward copy tracks the kink line just written
    a_kink_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kink_we |=> (r_fwd_kink_vld && (r_fwd_kink_line == $past(r_s1_line))))
        else $error("kink forward copy lost its line");

    // reset empties both pipeline stages
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!r_s1_vld && !r_out_vld))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_circular_bit_range_flip_count_core.sv
`timescale 1ns / 100ps

module tb_circular_bit_range_flip_count_core;

    import cbrfc_pkg::*;

    // Codes past the defined operations; the block must answer them with zeros
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_TAIL   = 300;     // last transactions run with no idling
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    circular_bit_range_flip_count_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: shadow copies of both bit stores and the staging slots
    // ------------------------------------------------------------------
    logic [63:0] spin_bits [64];
    logic [63:0] kink_bits [64];
    logic [63:0] staged_bits [2];
    logic [5:0]  staged_addr [2];
    bit          slot_loaded [2];

    t_out_item   pending_results [$];   // predicted results, oldest first
    int          mismatches;
    int          cycle_count;
    bit          gaps_enabled;          // random idling on both sides
    int          stall_left;

    // Circular inclusive range first..last; first one past last covers all
    function automatic logic [63:0] arc_mask(input logic [5:0] first, input logic [5:0] last);
        logic [63:0] ones_word;
        ones_word = '1;
        if (first <= last)
            return (ones_word >> (63 - last)) & (ones_word << first);
        if (32'(last) + 1 >= 32'(first))
            return ones_word;
        // wrapped: everything except the gap last+1 .. first-1
        return ~((ones_word >> (63 - (first - 1))) & (ones_word << (last + 1)));
    endfunction

    function automatic t_out_item apply_op(input t_in_item it);
        t_out_item   r;
        logic [63:0] m;
        r = '0;
        case (it.operation)
            OP_PROBE: begin
                m = arc_mask(it.first_slice, it.last_slice);
                r.ones_count = COUNT_W'($countones(spin_bits[it.line] & m));
                staged_bits[it.slot] = spin_bits[it.line] ^ m;
                staged_addr[it.slot] = it.line;
                slot_loaded[it.slot] = 1'b1;
            end
            OP_COMMIT: begin
                spin_bits[staged_addr[it.slot]] = staged_bits[it.slot];
            end
            OP_KCOUNT: begin
                m = arc_mask(it.first_slice, it.last_slice);
                r.ones_count = COUNT_W'($countones(kink_bits[it.line] & m));
            end
            OP_KREAD: begin
                r.bit_value = kink_bits[it.line][it.bit_slice];
            end
            OP_KTOGGLE: begin
                r.bit_value = kink_bits[it.line][it.bit_slice];
                kink_bits[it.line][it.bit_slice] = ~r.bit_value;
            end
            OP_LCOUNT: begin
                r.ones_count = COUNT_W'($countones(spin_bits[it.line]));
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        t_in_item  item;
        bit        pinned;    // want is typed in rather than predicted
        t_out_item want;
    } t_dir_row;

    t_dir_row directed_rows [$];

    function automatic void add_row(input logic [OP_W-1:0] op, input int ln, input int first,
                                    input int last, input int bsl, input int sl,
                                    input bit pinned, input int cnt, input int bv);
        t_dir_row row;
        row.item.operation   = op;
        row.item.line        = LINE_W'(ln);
        row.item.first_slice = SLICE_W'(first);
        row.item.last_slice  = SLICE_W'(last);
        row.item.bit_slice   = SLICE_W'(bsl);
        row.item.slot        = SLOT_W'(sl);
        row.pinned           = pinned;
        row.want.ones_count  = COUNT_W'(cnt);
        row.want.bit_value   = bv[0];
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus: probes and commits, mostly on a handful of lines so
    // the stores fill up, plus kink traffic and spare codes as noise
    // ------------------------------------------------------------------
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it.operation   = OP_PROBE;
        it.line        = ($urandom_range(0, 3) != 0) ? LINE_W'($urandom_range(0, 7))
                                                     : LINE_W'($urandom_range(0, 63));
        it.first_slice = SLICE_W'($urandom_range(0, 63));
        it.last_slice  = SLICE_W'($urandom_range(0, 63));
        it.bit_slice   = SLICE_W'($urandom_range(0, 63));
        it.slot        = SLOT_W'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
            it.first_slice = it.last_slice + 1'b1;     // full wrap
        pick = $urandom_range(0, 99);
        if (pick < 25)
            it.operation = OP_PROBE;
        else if (pick < 45) begin
            // commit only a slot some probe has filled
            if (slot_loaded[0] || slot_loaded[1]) begin
                it.operation = OP_COMMIT;
                if (!slot_loaded[it.slot])
                    it.slot = ~it.slot;
            end
        end else if (pick < 57)
            it.operation = OP_KCOUNT;
        else if (pick < 67)
            it.operation = OP_KREAD;
        else if (pick < 82)
            it.operation = OP_KTOGGLE;
        else if (pick < 95)
            it.operation = OP_LCOUNT;
        else
            it.operation = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
        return it;
    endfunction

    // One transaction: optional idle burst, then hold until accepted.
    // Called at a falling edge, returns at a falling edge.
    task automatic drive_item(input t_in_item it, input bit pinned, input t_out_item want);
        t_out_item predicted;
        if (gaps_enabled && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = apply_op(it);
        pending_results.push_back(pinned ? want : predicted);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall in random bursts while idling is on
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!gaps_enabled || !i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker: each accepted transaction against the oldest prediction
    t_out_item oldest;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with none outstanding, ones_count %0d bit_value %0d",
                         $time, o_data.ones_count, o_data.bit_value);
            end else begin
                oldest = pending_results.pop_front();
                if (o_data.ones_count !== oldest.ones_count) begin
                    mismatches++;
                    $display("%0t: ones_count expected %0d actual %0d",
                             $time, oldest.ones_count, o_data.ones_count);
                end
                if (o_data.bit_value !== oldest.bit_value) begin
                    mismatches++;
                    $display("%0t: bit_value expected %0d actual %0d",
                             $time, oldest.bit_value, o_data.bit_value);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_stall      = 1'b0;
        mismatches   = 0;
        cycle_count  = 0;
        stall_left   = 0;
        gaps_enabled = 1'b0;
        foreach (spin_bits[k]) begin
            spin_bits[k] = '0;
            kink_bits[k] = '0;
        end
        foreach (slot_loaded[k]) begin
            slot_loaded[k] = 1'b0;
            staged_bits[k] = '0;
            staged_addr[k] = '0;
        end

        //       op           line first last  bit slot pin  cnt bv
        add_row(OP_LCOUNT,    0,    0,    0,    0,  0,   1,   0,  0);  // stores clear after reset
        add_row(OP_LCOUNT,    63,   0,    0,    0,  0,   1,   0,  0);
        add_row(OP_KCOUNT,    63,   0,    63,   0,  0,   1,   0,  0);
        add_row(OP_KREAD,     0,    0,    0,    0,  0,   1,   0,  0);
        add_row(OP_PROBE,     0,    0,    63,   0,  0,   1,   0,  0);  // whole line, no wrap
        add_row(OP_COMMIT,    0,    0,    0,    0,  0,   1,   0,  0);
        add_row(OP_LCOUNT,    0,    0,    0,    0,  0,   1,   64, 0);  // line now all ones
        add_row(OP_PROBE,     63,   10,   9,    0,  1,   1,   0,  0);  // full wrap
        add_row(OP_COMMIT,    0,    0,    0,    0,  1,   1,   0,  0);
        add_row(OP_LCOUNT,    63,   0,    0,    0,  0,   1,   64, 0);
        add_row(OP_PROBE,     0,    60,   3,    0,  1,   0,   0,  0);  // wrapped range
        add_row(OP_PROBE,     63,   63,   63,   0,  0,   0,   0,  0);  // single top slice
        add_row(OP_COMMIT,    0,    0,    0,    0,  1,   1,   0,  0);
        add_row(OP_COMMIT,    0,    0,    0,    0,  0,   1,   0,  0);
        add_row(OP_LCOUNT,    0,    0,    0,    0,  0,   0,   0,  0);
        add_row(OP_KTOGGLE,   5,    0,    0,    63, 0,   1,   0,  0);
        add_row(OP_KTOGGLE,   5,    0,    0,    0,  0,   1,   0,  0);
        add_row(OP_KREAD,     5,    0,    0,    63, 0,   1,   0,  1);
        add_row(OP_KCOUNT,    5,    63,   0,    0,  0,   0,   0,  0);  // wrap over both ends
        add_row(OP_KCOUNT,    5,    1,    62,   0,  0,   0,   0,  0);
        add_row(OP_SPARE_LO,  63,   63,   63,   63, 1,   1,   0,  0);
        add_row(OP_SPARE_HI,  63,   63,   63,   63, 1,   1,   0,  0);
        add_row(OP_KTOGGLE,   5,    0,    0,    63, 0,   1,   0,  1);
        add_row(OP_PROBE,     42,   0,    0,    0,  1,   0,   0,  0);  // single bottom slice

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k])
            drive_item(directed_rows[k].item, directed_rows[k].pinned, directed_rows[k].want);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // idle in stretches of 100 transactions, every third stretch quiet
            gaps_enabled = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 100) % 3 != 2);
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            drive_item(random_item(), 1'b0, '0);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
